/* sv/dqse_pkg.sv */
// ============================================================================
// dqse_pkg
// Shared types, constants and ring-index helpers for the deque with search
// and extremes.
// ============================================================================
package dqse_pkg;

   // Storage geometry.
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Fixed field widths on the ports.
   localparam int VAL_W       = 32;
   localparam int POS_W       = 4;
   localparam int FUNC_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   // Depth as a ring-sum-wide constant.
   localparam logic [IDX_W:0] DEPTH_S = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // Operation codes.
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_BACK  = 3'd0,
      FN_POP_BACK   = 3'd1,
      FN_PUSH_FRONT = 3'd2,
      FN_POP_FRONT  = 3'd3,
      FN_FIND       = 3'd4,
      FN_MAX        = 3'd5,
      FN_MIN        = 3'd6,
      FN_EMPTY_TEST = 3'd7
   } func_type;

   // Completion status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Ring index plus offset, both below the depth.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[IDX_W-1:0];
   endfunction

   // Ring index minus one.
   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] res;
      if (a == '0) begin
         res = LAST_IDX;
      end else begin
         res = a - 1'b1;
      end
      return res;
   endfunction

   // Port value to stored entry: sign-extend, then cut to the entry width.
   function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
      logic [DATA_WIDTH+VAL_W-1:0] wide;
      wide = {{DATA_WIDTH{v[VAL_W-1]}}, v};
      return wide[DATA_WIDTH-1:0];
   endfunction

   // Stored entry to port value: sign-extend, then keep the port width.
   function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH+VAL_W-1:0] wide;
      wide = {{VAL_W{v[DATA_WIDTH-1]}}, v};
      return wide[VAL_W-1:0];
   endfunction

   // Ring offset to reported position; deep queues wrap modulo 16.
   function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
      logic [IDX_W+POS_W-1:0] wide;
      wide = {{POS_W{1'b0}}, idx};
      return wide[POS_W-1:0];
   endfunction

endpackage

/* sv/dqse_ram.sv */
// ============================================================================
// dqse_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No reset: contents are undefined until written.
// ============================================================================
module dqse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/deque_with_search_and_extremes_unit.sv */
// ============================================================================
// deque_with_search_and_extremes_unit
// Bounded double-ended queue in a ring memory, with find, max and min scans.
// ============================================================================
// One request is handled at a time. Pushes and the empty test pass through the
// execute and response states, pops also through a pop state that takes the
// read data, and find, max and min through a scan state that reads the entry
// memory through its single read port one entry per cycle (find stops at the
// first match). A finished result waits in the output register, and the next
// request is accepted while it waits. Max and min report the last entry,
// counted from the front, that holds the extreme value; positions are
// reported modulo 16. The entry memory is not cleared at reset: only entries
// inside the live range are ever read.
module deque_with_search_and_extremes_unit
   import dqse_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] value_in
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [2:0] func
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] value_out, [35:32] position,
                                              // [39:36] zero
   output logic [RSP_TUSER_W-1:0] rsp_tuser   // [1:0] status, [2] is_empty
);

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_POP  = 5'b00100,
      S_SCAN = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   func_type               func_ff, func_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       iss_ff, iss_in;
   status_type             res_status_ff, res_status_in;
   logic [DATA_WIDTH-1:0]  res_value_ff, res_value_in;
   logic [IDX_W-1:0]       res_pos_ff, res_pos_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data;

   logic                   req_fire;
   logic                   out_free;
   logic [CNT_W-1:0]       cnt_m1;
   logic                   is_full;
   logic                   is_empty_q;
   logic                   scan_last;
   logic                   take;

   // Entry storage.
   dqse_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshake qualifiers and occupancy flags.
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign cnt_m1     = count_ff - 1'b1;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty_q = (count_ff == '0);
   assign scan_last  = (cnt_m1 == CNT_W'(iss_ff));

   // Sequencer, memory access and result assembly.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_pos_in    = res_pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      take          = 1'b0;

      // The response register empties when the consumer takes it.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in  = func_type'(req_tuser[FUNC_W-1:0]);
               val_in   = to_store(req_tdata[VAL_W-1:0]);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_status_in = ST_OK;
            res_value_in  = '0;
            res_pos_in    = '0;
            state_in      = S_RESP;
            case (func_ff)
               FN_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = wrap_add(front_ff, count_ff[IDX_W-1:0]);
                     count_in = count_ff + 1'b1;
                  end
               end
               FN_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = wrap_dec(front_ff);
                     front_in = wrap_dec(front_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               FN_POP_BACK: begin
                  if (is_empty_q) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = wrap_add(front_ff, cnt_m1[IDX_W-1:0]);
                     count_in = cnt_m1;
                     state_in = S_POP;
                  end
               end
               FN_POP_FRONT: begin
                  if (is_empty_q) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     front_in = wrap_add(front_ff, IDX_W'(1));
                     count_in = cnt_m1;
                     state_in = S_POP;
                  end
               end
               FN_FIND, FN_MAX, FN_MIN: begin
                  if (is_empty_q) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = front_ff;
                     iss_in   = '0;
                     state_in = S_SCAN;
                     if (func_ff == FN_FIND) begin
                        res_status_in = ST_NOT_FOUND;
                     end
                  end
               end
               default: begin
                  // Empty test: status ok, only is_empty matters.
               end
            endcase
         end

         S_POP: begin
            res_value_in = rd_data;
            state_in     = S_RESP;
         end

         S_SCAN: begin
            // rd_data holds the entry at offset iss_ff from the front.
            if (func_ff == FN_FIND) begin
               if (rd_data == val_ff) begin
                  res_status_in = ST_OK;
                  res_pos_in    = iss_ff;
                  state_in      = S_RESP;
               end else if (scan_last) begin
                  state_in = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(front_ff, iss_ff + 1'b1);
                  iss_in  = iss_ff + 1'b1;
               end
            end else begin
               if (iss_ff == '0) begin
                  take = 1'b1;
               end else if (func_ff == FN_MAX) begin
                  take = ($signed(rd_data) >= $signed(res_value_ff));
               end else begin
                  take = ($signed(rd_data) <= $signed(res_value_ff));
               end
               if (take) begin
                  res_value_in = rd_data;
                  res_pos_in   = iss_ff;
               end
               if (scan_last) begin
                  state_in = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(front_ff, iss_ff + 1'b1);
                  iss_in  = iss_ff + 1'b1;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(RSP_TDATA_W - VAL_W - POS_W){1'b0}},
                                to_pos(res_pos_ff), to_out(res_value_ff)};
               rsp_tuser_in  = {is_empty_q, res_status_ff};
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      val_ff        <= val_in;
      iss_ff        <= iss_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_pos_ff    <= res_pos_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* verif/deque_with_search_and_extremes_unit_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// deque_with_search_and_extremes_unit_test
// Self-checking testbench for the deque with search and extremes. Requests
// are driven with random gaps and responses are taken with random stalls.
// A scoreboard mirrors the ring contents, predicts one response per accepted
// request, and compares every response field by field in arrival order.
// ============================================================================
module deque_with_search_and_extremes_unit_test;
   import dqse_pkg::*;

   // One predicted response.
   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      logic             is_empty;
   } deque_reply_type;

   // Scoreboard: shadow copy of the ring and the queue of predicted replies.
   class deque_scoreboard;
      logic [DATA_WIDTH-1:0] ring[DEPTH];
      int unsigned           head;
      int unsigned           fill;
      deque_reply_type       pending_replies[$];
      int unsigned           errors;
      int unsigned           replies_seen;

      function new();
         head         = 0;
         fill         = 0;
         errors       = 0;
         replies_seen = 0;
      endfunction

      // Sign-extend a port value and cut it to the entry width.
      function logic [DATA_WIDTH-1:0] fit_entry(logic [VAL_W-1:0] v);
         logic signed [63:0] wide;
         wide = signed'(v);
         return wide[DATA_WIDTH-1:0];
      endfunction

      // Sign-extend an entry and keep the port width.
      function logic [VAL_W-1:0] widen_entry(logic [DATA_WIDTH-1:0] e);
         logic signed [63:0] wide;
         wide = signed'(e);
         return wide[VAL_W-1:0];
      endfunction

      // Update the shadow ring for an accepted request and queue its reply.
      function void apply_request(func_type op, logic [VAL_W-1:0] operand);
         deque_reply_type              r;
         logic [DATA_WIDTH-1:0]        key;
         logic signed [DATA_WIDTH-1:0] cur;
         logic signed [DATA_WIDTH-1:0] top;
         int unsigned                  best;
         r        = '0;
         r.status = ST_OK;
         key      = fit_entry(operand);
         case (op)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
               if (fill == DEPTH) begin
                  r.status = ST_FULL;
               end else if (op == FN_PUSH_BACK) begin
                  ring[(head + fill) % DEPTH] = key;
                  fill++;
               end else begin
                  head       = (head + DEPTH - 1) % DEPTH;
                  ring[head] = key;
                  fill++;
               end
            end
            FN_POP_BACK: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  fill--;
                  r.value = widen_entry(ring[(head + fill) % DEPTH]);
               end
            end
            FN_POP_FRONT: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.value = widen_entry(ring[head]);
                  head    = (head + 1) % DEPTH;
                  fill--;
               end
            end
            FN_FIND: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.status = ST_NOT_FOUND;
                  for (int unsigned i = 0; i < fill; i++) begin
                     if (ring[(head + i) % DEPTH] == key) begin
                        r.status   = ST_OK;
                        r.position = POS_W'(i);
                        break;
                     end
                  end
               end
            end
            FN_MAX, FN_MIN: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  // Ties move the answer toward the back.
                  best = 0;
                  top  = signed'(ring[head]);
                  for (int unsigned i = 1; i < fill; i++) begin
                     cur = signed'(ring[(head + i) % DEPTH]);
                     if ((op == FN_MAX) ? (cur >= top) : (cur <= top)) begin
                        top  = cur;
                        best = i;
                     end
                  end
                  r.value    = widen_entry(ring[(head + best) % DEPTH]);
                  r.position = POS_W'(best);
               end
            end
            default: begin
            end
         endcase
         r.is_empty = (fill == 0);
         pending_replies.push_back(r);
      endfunction

      function void report_mismatch(string field, longint unsigned expected_val,
                                    longint unsigned actual_val);
         errors++;
         if (errors <= 10) begin
            $display("reply %0d: %s expected 0x%0h, got 0x%0h",
                     replies_seen, field, expected_val, actual_val);
         end
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_reply(logic [RSP_TDATA_W-1:0] data,
                                logic [RSP_TUSER_W-1:0] user);
         deque_reply_type e;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing pending, tdata", 0, data);
            return;
         end
         e = pending_replies.pop_front();
         if (user[1:0] != e.status) begin
            report_mismatch("status", e.status, user[1:0]);
         end
         if (user[2] != e.is_empty) begin
            report_mismatch("is_empty", e.is_empty, user[2]);
         end
         if (data[31:0] != e.value) begin
            report_mismatch("value_out", e.value, data[31:0]);
         end
         if (data[35:32] != e.position) begin
            report_mismatch("position", e.position, data[35:32]);
         end
         if (data[RSP_TDATA_W-1:36] != '0) begin
            report_mismatch("tdata padding", 0, data[RSP_TDATA_W-1:36]);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   steady;

   deque_scoreboard sb = new();

   deque_with_search_and_extremes_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Receiver stalls at random except during the steady stretch.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 24);
   end

   // Every accepted response transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_reply(rsp_tdata, rsp_tuser);
      end
   end

   // Drive one request transaction, called and returning at a falling edge.
   task automatic issue_request(func_type op, logic [VAL_W-1:0] operand);
      if (!steady) begin
         while ($urandom_range(99) < 24) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= operand;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.apply_request(op, operand);
      @(negedge clock);
   endtask

   // Operand mix: a small pool for find hits and ties, extremes, full random.
   function automatic logic [VAL_W-1:0] pick_operand();
      logic [VAL_W-1:0] pool[8];
      int unsigned      r;
      pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h5, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h55AA, 32'hFFFF_FF9C};
      r = $urandom_range(99);
      if (r < 45) begin
         return pool[$urandom_range(7)];
      end else if (r < 55) begin
         return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      return $urandom();
   endfunction

   // Main stimulus.
   initial begin
      int unsigned mode;
      int unsigned r;
      func_type    op;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FN_EMPTY_TEST;
      steady     = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation but the pushes on an empty queue.
      issue_request(FN_EMPTY_TEST, 32'h0);
      issue_request(FN_POP_BACK,   32'hFFFF_FFFF);
      issue_request(FN_POP_FRONT,  32'h0);
      issue_request(FN_FIND,       32'h0);
      issue_request(FN_MAX,        32'h0);
      issue_request(FN_MIN,        32'h0);
      // Extremes pushed at both ends, with ties for max and min.
      issue_request(FN_PUSH_BACK,  32'h7FFF_FFFF);
      issue_request(FN_PUSH_FRONT, 32'h8000_0000);
      issue_request(FN_PUSH_BACK,  32'h7FFF_FFFF);
      issue_request(FN_PUSH_FRONT, 32'h8000_0000);
      issue_request(FN_PUSH_BACK,  32'h0);
      issue_request(FN_PUSH_BACK,  32'hFFFF_FFFF);
      issue_request(FN_FIND,       32'h0);
      issue_request(FN_FIND,       32'h7FFF_FFFF);
      issue_request(FN_FIND,       32'h1234_5678);
      issue_request(FN_MAX,        32'h0);
      issue_request(FN_MIN,        32'h0);
      issue_request(FN_EMPTY_TEST, 32'hFFFF_FFFF);
      issue_request(FN_POP_BACK,   32'h0);
      issue_request(FN_POP_FRONT,  32'h0);

      // Random: blocks that lean toward filling, draining or a mix, so the
      // queue often reaches both full and empty and the ring wraps.
      mode = 0;
      for (int n = 0; n < 2000; n++) begin
         if (n % 50 == 0) begin
            mode = $urandom_range(2);
         end
         steady = (n >= 900 && n < 1250);
         r = $urandom_range(99);
         if (r < ((mode == 0) ? 60 : (mode == 1) ? 15 : 35)) begin
            op = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
         end else if (r < ((mode == 0) ? 75 : (mode == 1) ? 70 : 60)) begin
            op = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
         end else begin
            case ($urandom_range(3))
               0:       op = FN_FIND;
               1:       op = FN_MAX;
               2:       op = FN_MIN;
               default: op = FN_EMPTY_TEST;
            endcase
         end
         issue_request(op, pick_operand());
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // Drain the remaining responses, then watch for strays.
      while (sb.pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/dqse_pkg.sv
sv/dqse_ram.sv
sv/deque_with_search_and_extremes_unit.sv
verif/deque_with_search_and_extremes_unit_test.sv
